// File: sv/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg - shared types and constants of the fractional delay line
// Register indexes, fixed field widths, queue sizing and the queue status
// struct that the front, queue and back modules share.
// ----------------------------------------------------------------------------
package fdl_pkg;

    // default build values
    localparam int DEF_STORE_DEPTH   = 4096;
    localparam int DEF_SAMPLE_BITS   = 16;
    localparam int DEF_FRACTION_BITS = 8;

    // fixed field widths
    localparam int DELAY_BITS   = 20;
    localparam int REG_BITS     = 13;
    localparam int CFG_IDX_BITS = 2;

    // ring length after reset
    localparam logic [REG_BITS-1:0] RING_RESET = 13'd4096;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODULATED_MODE = 2'd0,
        CFG_FIXED_DELAY    = 2'd1,
        CFG_RING_LENGTH    = 2'd2
    } t_cfg_index;

    // queue status seen by the front and back
    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] level;
    } t_q_status;

endpackage

// File: sv/fdl_front.sv
// ----------------------------------------------------------------------------
// fdl_front - configuration, read address generation and delay store
// Holds the registers and write position, works out the two neighbour
// addresses and fraction of each word, reads both and writes the new sample
// in the same cycle, and clears the store after reset.
// ----------------------------------------------------------------------------
module fdl_front
    import fdl_pkg::*;
#(
    parameter int STORE_DEPTH   = DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration writes
    input  logic                        i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [REG_BITS-1:0]         i_cfg_data,
    // input words
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    input  logic [DELAY_BITS-1:0]       i_delay,
    // toward the queue
    input  t_q_status                   i_q_stat,
    output logic                        o_push,
    output logic [SAMPLE_BITS-1:0]      o_b1,
    output logic [SAMPLE_BITS-1:0]      o_b2,
    output logic [((FRACTION_BITS > 0) ? FRACTION_BITS : 1)-1:0] o_frac
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = $clog2(STORE_DEPTH + 1);
    localparam int FW = (FRACTION_BITS > 0) ? FRACTION_BITS : 1;
    localparam int PA = LW + 1 + FRACTION_BITS;
    localparam int PB = REG_BITS + FRACTION_BITS;
    localparam int PAB = (PA > PB) ? PA : PB;
    localparam int PW = (PAB > DELAY_BITS) ? PAB : DELAY_BITS;

    // clamp a written ring length to the usable range
    function automatic logic [LW-1:0] clamp_len(input logic [REG_BITS-1:0] v);
        logic [LW-1:0] res;
        if (32'(v) < 32'd2) begin
            res = LW'(2);
        end else if (32'(v) > 32'(STORE_DEPTH)) begin
            res = LW'(STORE_DEPTH);
        end else begin
            res = LW'(v);
        end
        return res;
    endfunction

    logic                   r_mode;
    logic [REG_BITS-1:0]    r_fixed;
    logic [LW-1:0]          r_len;
    logic [AW-1:0]          r_wp;
    logic                   r_clr;
    logic [AW-1:0]          r_clr_addr;
    logic                   r_rd_vld;
    logic [FW-1:0]          r_frac;
    logic [SAMPLE_BITS-1:0] r_rd1;
    logic [SAMPLE_BITS-1:0] r_rd2;
    logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

    logic                   accept;
    logic [AW-1:0]          wp_eff;
    logic [PW-1:0]          q_dly;
    logic [PW-1:0]          wp_sh;
    logic [PW-1:0]          top_sh;
    logic [PW-1:0]          last_sh;
    logic [PW-1:0]          pos;
    logic [PW-1:0]          i1_full;
    logic [AW-1:0]          i1;
    logic [LW-1:0]          i2p;
    logic [AW-1:0]          i2;
    logic [FW-1:0]          frac_w;
    logic [LW-1:0]          wpp;
    logic [AW-1:0]          n_wp;
    logic [QCNT_W:0]        busy;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [SAMPLE_BITS-1:0] mem_wd;

    // room for one more word once the word in the read stage lands
    assign busy    = (QCNT_W + 1)'(i_q_stat.level) + (QCNT_W + 1)'(r_rd_vld);
    assign o_ready = !r_clr && (busy < (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept  = i_valid && o_ready;

    // neighbour addresses and fraction
    always_comb begin
        wp_eff  = (LW'(r_wp) >= r_len) ? '0 : r_wp;
        q_dly   = r_mode ? PW'(i_delay) : (PW'(r_fixed) << FRACTION_BITS);
        wp_sh   = PW'(wp_eff) << FRACTION_BITS;
        top_sh  = (PW'(wp_eff) + PW'(r_len)) << FRACTION_BITS;
        last_sh = (PW'(r_len) - PW'(1)) << FRACTION_BITS;
        if (q_dly <= wp_sh) begin
            pos = wp_sh - q_dly;
        end else if (q_dly > top_sh) begin
            pos = last_sh;
        end else begin
            pos = top_sh - q_dly;
        end
        i1_full = pos >> FRACTION_BITS;
        i1      = (i1_full >= PW'(r_len)) ? AW'(r_len - LW'(1)) : AW'(i1_full);
        frac_w  = (FRACTION_BITS > 0) ? pos[FW-1:0] : '0;
        i2p     = LW'(i1) + LW'(1);
        i2      = (i2p >= r_len) ? '0 : AW'(i2p);
        wpp     = LW'(wp_eff) + LW'(1);
        n_wp    = (wpp >= r_len) ? '0 : AW'(wpp);
    end

    // store write port: clearing sweep or new sample
    assign mem_we = r_clr || accept;
    assign mem_wa = r_clr ? r_clr_addr : wp_eff;
    assign mem_wd = r_clr ? '0 : i_sample;

    // delay store, two registered reads, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd1 <= mem[i1];
        r_rd2 <= mem[i2];
    end

    // fraction travels alongside the read
    always_ff @(posedge i_clk) begin
        r_frac <= frac_w;
    end

    // control state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_fixed    <= '0;
            r_len      <= clamp_len(RING_RESET);
            r_wp       <= '0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MODULATED_MODE: r_mode  <= i_cfg_data[0];
                    CFG_FIXED_DELAY:    r_fixed <= i_cfg_data;
                    CFG_RING_LENGTH:    r_len   <= clamp_len(i_cfg_data);
                    default: ;
                endcase
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(STORE_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (accept) begin
                r_wp <= n_wp;
            end
            r_rd_vld <= accept;
        end
    end

    assign o_push = r_rd_vld;
    assign o_b1   = r_rd1;
    assign o_b2   = r_rd2;
    assign o_frac = r_frac;

endmodule

// File: sv/fdl_queue.sv
// ----------------------------------------------------------------------------
// fdl_queue - short queue between front and back
// Holds neighbour pairs with their fraction so the front keeps taking words
// while the output is stalled.
// ----------------------------------------------------------------------------
module fdl_queue
    import fdl_pkg::*;
#(
    parameter int WIDTH = 2 * DEF_SAMPLE_BITS + DEF_FRACTION_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_stat
);

    logic [WIDTH-1:0]  r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_data       = r_slot[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.level = r_count;

endmodule

// File: sv/fdl_back.sv
// ----------------------------------------------------------------------------
// fdl_back - interpolation and output register
// Computes v1 + frac * (v2 - v1) with round half up and holds the result
// until the receiver takes it.
// ----------------------------------------------------------------------------
module fdl_back
    import fdl_pkg::*;
#(
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_q_status              i_q_stat,
    input  logic [2*SAMPLE_BITS+((FRACTION_BITS > 0) ? FRACTION_BITS : 1)-1:0] i_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_sample
);

    localparam int SB = SAMPLE_BITS;
    localparam int FW = (FRACTION_BITS > 0) ? FRACTION_BITS : 1;
    localparam int AC = SB + FW + 3;
    localparam logic signed [AC-1:0] HALF = (AC'(1) << FRACTION_BITS) >> 1;

    logic [SB-1:0]          b1;
    logic [SB-1:0]          b2;
    logic [FW-1:0]          frac;
    logic signed [SB:0]     diff;
    logic signed [FW:0]     fracs;
    logic signed [SB+FW+1:0] prod;
    logic signed [AC-1:0]   base;
    logic signed [AC-1:0]   acc;
    logic signed [AC-1:0]   res;
    logic [SB-1:0]          n_sample;
    logic                   r_vld;
    logic [SB-1:0]          r_sample;

    assign o_pop = !i_q_stat.empty && (!r_vld || i_ready);

    // linear interpolation, floor after adding one half
    always_comb begin
        b1       = i_data[SB-1:0];
        b2       = i_data[2*SB-1:SB];
        frac     = i_data[2*SB+FW-1:2*SB];
        diff     = $signed({b2[SB-1], b2}) - $signed({b1[SB-1], b1});
        fracs    = $signed({1'b0, frac});
        prod     = diff * fracs;
        base     = AC'($signed(b1)) <<< FRACTION_BITS;
        acc      = base + AC'(prod) + HALF;
        res      = acc >>> FRACTION_BITS;
        n_sample = res[SB-1:0];
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample <= n_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_pop) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    assign o_valid  = r_vld;
    assign o_sample = r_sample;

endmodule

// File: sv/fractional_delay_line_core.sv
// ----------------------------------------------------------------------------
// fractional_delay_line_core - circular audio delay line with interpolation
// Each input word reads the delayed sample and stores its own sample.
//
// Channels: s_axis carries sample_in and delay_amount, m_axis carries
// sample_out, one output word per input word, in order. The cfg channel
// writes mode (index 0), fixed delay (1) and ring length (2), always ready;
// the user writes it only while the line is idle; the block does not check.
// Path: the store read of a word is registered at the edge that accepts its
// input, then the word enters the queue and then the output register.
// Throughput: one word per cycle unless the output stalls; the store has one
// write and two read ports, so read, write and interpolation overlap the next.
// Reset: registers return to their defaults and the store is swept to zero,
// one entry a cycle over all STORE_DEPTH entries, with s_axis_tready low.
// Stall: a four-entry queue and the output register absorb a stalled
// receiver; s_axis_tready drops once they fill and rises as words leave.
// ----------------------------------------------------------------------------
module fractional_delay_line_core
    import fdl_pkg::*;
#(
    parameter int STORE_DEPTH   = DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int S_DATA_W     = ((SAMPLE_BITS + DELAY_BITS + 7) / 8) * 8,
    localparam int M_DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [REG_BITS-1:0]     i_cfg_data,
    // input words
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_DATA_W-1:0]     s_axis_tdata,   // sample_in, delay_amount
    // output words
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [M_DATA_W-1:0]     m_axis_tdata    // sample_out
);

    localparam int FW = (FRACTION_BITS > 0) ? FRACTION_BITS : 1;
    localparam int QW = 2 * SAMPLE_BITS + FW;

    logic                   push;
    logic                   pop;
    logic [SAMPLE_BITS-1:0] b1;
    logic [SAMPLE_BITS-1:0] b2;
    logic [FW-1:0]          frac;
    logic [QW-1:0]          q_in;
    logic [QW-1:0]          q_out;
    t_q_status              q_stat;
    logic [SAMPLE_BITS-1:0] sample_out;

    assign o_cfg_ready = 1'b1;

    fdl_front #(
        .STORE_DEPTH   (STORE_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_delay     (s_axis_tdata[SAMPLE_BITS+DELAY_BITS-1:SAMPLE_BITS]),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_b1        (b1),
        .o_b2        (b2),
        .o_frac      (frac)
    );

    assign q_in = {frac, b2, b1};

    fdl_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    fdl_back #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_data   (q_out),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_sample (sample_out)
    );

    assign m_axis_tdata = M_DATA_W'(sample_out);

endmodule

// File: sv/fdl_checker.sv
// ----------------------------------------------------------------------------
// fdl_checker - port-level checks of the fractional delay line
// Tracks words in flight from the handshakes and checks reset behavior, no
// output without input, stalled output holding and the internal queue bound.
// ----------------------------------------------------------------------------
module fdl_checker
    import fdl_pkg::*;
#(
    parameter int M_DATA_W = DEF_SAMPLE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata    // sample_out
);

    logic [3:0] r_inflight;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 4'(s_axis_tvalid && s_axis_tready)
                          - 4'(m_axis_tvalid && m_axis_tready);
        end
    end

    // the store sweep keeps the input closed right after reset
    a_rst_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("input open or output valid right after reset");

    // no output word without an accepted input word
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_inflight != 4'd0)
        else $error("output word with nothing in flight");

    // input only taken while the queue and output stage have room
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_inflight <= 4'(QUEUE_DEPTH))
        else $error("input ready with the pipeline full");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

endmodule

bind fractional_delay_line_core fdl_checker #(
    .M_DATA_W (M_DATA_W)
) u_fdl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/fractional_delay_line_core_tb.sv
// ----------------------------------------------------------------------------
// fractional_delay_line_core_tb - self-checking bench of the delay line core
// Streams sample words through the core under random source gaps and sink
// stalls. A behavioral copy of the delay store predicts every output word:
// fixed whole-frame reads, and fractional reads that blend two neighbors with
// round-half-up. A short directed table covers the corner cases, then random
// phases each reprogram the mode, the fixed delay and the ring length.
// ----------------------------------------------------------------------------
module fractional_delay_line_core_tb;
    import fdl_pkg::*;

    localparam int SMP_W     = DEF_SAMPLE_BITS;
    localparam int FRAC_W    = DEF_FRACTION_BITS;
    localparam int DEPTH     = DEF_STORE_DEPTH;
    localparam int S_W       = ((SMP_W + DELAY_BITS + 7) / 8) * 8;
    localparam int M_W       = ((SMP_W + 7) / 8) * 8;
    localparam int LIMIT     = 400000;
    localparam int N_PHASES  = 8;
    localparam int N_DIR     = 25;

    // index past the end of the register list, writes to it are dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    // one directed step: a register write or a sample word
    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_BITS-1:0]  idx;    // ignored on word rows
        logic [REG_BITS-1:0]      val;
        logic [SMP_W-1:0]         smp;
        logic [DELAY_BITS-1:0]    dly;
        logic                     typed;  // use want instead of the prediction
        logic [SMP_W-1:0]         want;
    } t_row;

    localparam t_row DIR_TAB [0:N_DIR-1] = '{
        // store is clear after reset: fixed mode, zero delay reads zeros
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h7FFF, 20'h00000, 1'b1, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h8000, 20'hFFFFF, 1'b1, 16'h0000},
        // ring below minimum acts as 2, write position wraps to zero
        '{ROW_CFG,  CFG_RING_LENGTH,    13'd0,    16'h0000, 20'h00000, 1'b0, 16'h0000},
        '{ROW_CFG,  CFG_FIXED_DELAY,    13'd1,    16'h0000, 20'h00000, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h0001, 20'h00000, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'hFFFF, 20'h00000, 1'b0, 16'h0000},
        // fixed delay past the ring clamps to the last frame
        '{ROW_CFG,  CFG_FIXED_DELAY,    13'h1FFF, 16'h0000, 20'h00000, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h7FFF, 20'h00000, 1'b0, 16'h0000},
        // modulated mode on a two-frame ring
        '{ROW_CFG,  CFG_MODULATED_MODE, 13'd1,    16'h0000, 20'h00000, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h8000, 20'h00000, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h7FFF, 20'h00080, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h0000, 20'h00180, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h8000, 20'hFFFFF, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h7FFF, 20'h00201, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h8001, 20'h000FF, 1'b0, 16'h0000},
        // write to an index past the list must change nothing
        '{ROW_CFG,  CFG_IDX_SPARE,      13'h1FFF, 16'h0000, 20'h00000, 1'b0, 16'h0000},
        // ring above the store depth acts as the full store
        '{ROW_CFG,  CFG_RING_LENGTH,    13'h1FFF, 16'h0000, 20'h00000, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h8000, 20'h00101, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h7FFF, 20'hFFF80, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h5A5A, 20'h10000, 1'b0, 16'h0000},
        // fixed delay equal to the ring reads the write slot
        '{ROW_CFG,  CFG_RING_LENGTH,    13'd4096, 16'h0000, 20'h00000, 1'b0, 16'h0000},
        '{ROW_CFG,  CFG_MODULATED_MODE, 13'd0,    16'h0000, 20'h00000, 1'b0, 16'h0000},
        '{ROW_CFG,  CFG_FIXED_DELAY,    13'd4096, 16'h0000, 20'h00000, 1'b0, 16'h0000},
        '{ROW_WORD, CFG_IDX_SPARE,      13'd0,    16'h1234, 20'h00000, 1'b0, 16'h0000},
        '{ROW_CFG,  CFG_FIXED_DELAY,    13'd0,    16'h0000, 20'h00000, 1'b0, 16'h0000}
    };

    // DUT connections
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index   = '0;
    logic [REG_BITS-1:0]     i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_W-1:0]          s_axis_tdata  = '0;  // sample_in, delay_amount
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_W-1:0]          m_axis_tdata;       // sample_out

    // behavioral copy of the line
    logic [SMP_W-1:0]    line_mem [0:DEPTH-1];
    logic [11:0]         wr_pos;
    logic                mod_mode;
    logic [REG_BITS-1:0] fixed_dly;
    logic [REG_BITS-1:0] ring_len;

    logic [SMP_W-1:0]    delayed_q [$];   // delayed samples still to arrive
    logic [SMP_W-1:0]    out_want;
    int unsigned         err_cnt   = 0;
    int unsigned         cyc_cnt   = 0;
    int unsigned         src_idle  = 10;  // percent chance of a source gap
    int unsigned         sink_idle = 10;  // percent chance of a sink stall
    int unsigned         stall_cnt = 0;
    bit                  word_on   = 1'b0;
    bit                  cfg_on    = 1'b0;

    fractional_delay_line_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // ring length actually in use
    function automatic longint ring_eff();
        longint len;
        len = ring_len;
        if (len < 2) len = 2;
        if (len > DEPTH) len = DEPTH;
        return len;
    endfunction

    // read the delayed sample, then store the new one and advance
    function automatic logic [SMP_W-1:0] line_step(input logic [SMP_W-1:0] smp,
                                                   input logic [DELAY_BITS-1:0] dly);
        longint           len, wp, rd, fd, span, pos, i1, i2, frac;
        longint           b1, b2, acc;
        logic [SMP_W-1:0] res;
        len = ring_eff();
        wp  = wr_pos;
        if (wp >= len) wp = 0;
        if (!mod_mode) begin
            fd = fixed_dly;
            rd = wp + len - fd;
            if (rd >= len) rd = rd - len;
            else if (rd < 0) rd = len - 1;
            res = line_mem[rd];
        end else begin
            span = len << FRAC_W;
            pos  = ((wp + len) << FRAC_W) - longint'(dly);
            if (pos >= span) pos = pos - span;
            else if (pos < 0) pos = (len - 1) << FRAC_W;
            i1 = pos >> FRAC_W;
            if (i1 >= len) i1 = len - 1;
            frac = pos & ((64'sd1 << FRAC_W) - 1);
            i2 = i1 + 1;
            if (i2 >= len) i2 = 0;
            // offset binary keeps the blend non-negative
            b1  = line_mem[i1] ^ {1'b1, {(SMP_W-1){1'b0}}};
            b2  = line_mem[i2] ^ {1'b1, {(SMP_W-1){1'b0}}};
            acc = b1 * ((64'sd1 << FRAC_W) - frac) + b2 * frac + (64'sd1 << (FRAC_W - 1));
            res = acc[FRAC_W +: SMP_W] ^ {1'b1, {(SMP_W-1){1'b0}}};
        end
        line_mem[wp] = smp;
        wp = wp + 1;
        if (wp >= len) wp = 0;
        wr_pos = wp[11:0];
        return res;
    endfunction

    // present one sample word, wait for acceptance, queue its delayed sample
    task automatic send_word(input logic [SMP_W-1:0] smp, input logic [DELAY_BITS-1:0] dly,
                             input bit typed, input logic [SMP_W-1:0] want);
        logic [SMP_W-1:0] pred;
        if (cfg_on) begin
            i_cfg_valid <= 1'b0;
            cfg_on = 1'b0;
        end
        if (src_idle != 0 && $urandom_range(1, 100) <= src_idle) begin
            if (word_on) s_axis_tvalid <= 1'b0;
            word_on = 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_W'({dly, smp});
        word_on = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = line_step(smp, dly);
        delayed_q.push_back(typed ? want : pred);
    endtask

    // stop the source and wait for every queued word to come out
    task automatic drain_line();
        if (word_on) begin
            s_axis_tvalid <= 1'b0;
            word_on = 1'b0;
        end
        while (delayed_q.size() != 0) @(posedge i_clk);
    endtask

    // register write; valid stays up so back-to-back writes need no toggle
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [REG_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        cfg_on = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MODULATED_MODE: mod_mode  = val[0];
            CFG_FIXED_DELAY:    fixed_dly = val;
            CFG_RING_LENGTH:    ring_len  = val;
            default: ;
        endcase
    endtask

    // sink stalls in random bursts of random length
    always @(posedge i_clk) begin
        if (sink_idle == 0) begin
            stall_cnt     <= 0;
            m_axis_tready <= 1'b1;
        end else if (stall_cnt != 0) begin
            stall_cnt     <= stall_cnt - 1;
            m_axis_tready <= (stall_cnt == 1);
        end else if ($urandom_range(1, 100) <= sink_idle) begin
            m_axis_tready <= 1'b0;
            stall_cnt     <= $urandom_range(1, 13);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // output word check against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (delayed_q.size() == 0) begin
                err_cnt <= err_cnt + 1;
                $display("%0t: unexpected word, expected none, actual %h",
                         $time, m_axis_tdata[SMP_W-1:0]);
            end else begin
                out_want = delayed_q.pop_front();
                if (m_axis_tdata[SMP_W-1:0] !== out_want) begin
                    err_cnt <= err_cnt + 1;
                    $display("%0t: sample_out mismatch, expected %h, actual %h",
                             $time, out_want, m_axis_tdata[SMP_W-1:0]);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == LIMIT) begin
            $display("[fractional_delay_line_core] ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        longint              len;
        int unsigned         n_words;
        logic [SMP_W-1:0]    smp;
        logic [DELAY_BITS-1:0] dly;
        logic [REG_BITS-1:0] val;

        for (int k = 0; k < DEPTH; k++) line_mem[k] = '0;
        wr_pos    = '0;
        mod_mode  = 1'b0;
        fixed_dly = '0;
        ring_len  = RING_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_TAB[r].kind == ROW_CFG) begin
                drain_line();
                write_reg(DIR_TAB[r].idx, DIR_TAB[r].val);
            end else begin
                send_word(DIR_TAB[r].smp, DIR_TAB[r].dly, DIR_TAB[r].typed,
                          DIR_TAB[r].want);
            end
        end

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_line();
            if (ph == N_PHASES - 1) begin
                src_idle  = 0;
                sink_idle = 0;
            end else begin
                src_idle  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
                sink_idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            end

            write_reg(CFG_MODULATED_MODE, REG_BITS'(ph % 3 != 0));
            case ($urandom_range(0, 9))
                0:       val = 13'd0;
                1:       val = 13'd1;
                2:       val = 13'd2;
                3:       val = 13'h1FFF;
                4:       val = 13'd4096;
                8:       val = REG_BITS'($urandom_range(25, 300));
                9:       val = REG_BITS'($urandom);
                default: val = REG_BITS'($urandom_range(3, 24));
            endcase
            write_reg(CFG_RING_LENGTH, val);
            len = ring_eff();
            case ($urandom_range(0, 7))
                0:       val = 13'd0;
                1:       val = REG_BITS'(len);
                2:       val = REG_BITS'(len + 1);
                3:       val = 13'h1FFF;
                4:       val = REG_BITS'($urandom);
                default: val = REG_BITS'($urandom_range(0, len - 1));
            endcase
            write_reg(CFG_FIXED_DELAY, val);

            n_words = (ph == N_PHASES - 1) ? 110 : 105;
            for (int w = 0; w < n_words; w++) begin
                // hold the source until the line has emptied
                if (ph == 2 && w == 50) drain_line();
                case ($urandom_range(0, 9))
                    0:       smp = 16'h7FFF;
                    1:       smp = 16'h8000;
                    default: smp = SMP_W'($urandom);
                endcase
                if (!mod_mode) begin
                    dly = DELAY_BITS'($urandom);
                end else begin
                    case ($urandom_range(0, 9))
                        0:       dly = '0;
                        1:       dly = '1;
                        2:       dly = DELAY_BITS'($urandom);
                        3:       dly = DELAY_BITS'((len << FRAC_W) + $urandom_range(0, 255));
                        4:       dly = DELAY_BITS'($urandom_range(0, 255));
                        default: dly = DELAY_BITS'((longint'($urandom_range(0, len - 1)) << FRAC_W)
                                                   + $urandom_range(0, 255));
                    endcase
                end
                send_word(smp, dly, 1'b0, '0);
            end
        end

        drain_line();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("[fractional_delay_line_core] OK");
        else
            $display("[fractional_delay_line_core] ERROR");
        $finish;
    end

endmodule

// File: files.f
sv/fdl_pkg.sv
sv/fdl_front.sv
sv/fdl_queue.sv
sv/fdl_back.sv
sv/fractional_delay_line_core.sv
sv/fdl_checker.sv
sim/fractional_delay_line_core_tb.sv
